### src/ghash_accumulator_unit_assert.svh
// Assertion macros for the GHASH accumulator unit.
`ifndef GHASH_ACCUMULATOR_UNIT_ASSERT_SVH
`define GHASH_ACCUMULATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define GAU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define GAU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define GAU_ASSERT(lbl, clk, rst_n, prop, msg)
`define GAU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### src/gau_pkg.sv
// Shared types, constants and helpers of the GHASH accumulator unit.
`timescale 1ns / 1ps

package gau_pkg;

    localparam int BLK_W     = 128;
    localparam int HALF_W    = 64;
    localparam int VB_W      = 5;
    localparam int NBYTES    = 16;
    localparam int DIGIT_W   = 8;
    localparam int NSTEPS    = BLK_W / DIGIT_W;
    localparam int CNT_W     = 4;
    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 136;
    localparam int CFG_IDX_W = 1;

    localparam logic [BLK_W-1:0] GF_REDUCE = {8'hE1, 120'd0};

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_ABSORB = 2'd1,
        OP_FINISH = 2'd2,
        OP_CHECK  = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_HIGH = 1'b0,
        CFG_KEY_LOW  = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic accept;
        logic step;
        logic last;
        logic load_out;
    } t_dp_cmd;

    // keep leading valid_bytes bytes, byte 0 at the top
    function automatic logic [BLK_W-1:0] byte_mask(input logic [VB_W-1:0] n);
        logic [BLK_W-1:0] m;
        m = '0;
        for (int i = 0; i < NBYTES; i++) begin
            m[BLK_W-1-DIGIT_W*i -: DIGIT_W] = (n > VB_W'(i)) ? {DIGIT_W{1'b1}} : '0;
        end
        return m;
    endfunction

endpackage

### src/gau_controller.sv
// Sequencing control of the GHASH accumulator unit.
`timescale 1ns / 1ps

module gau_controller (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic [1:0]             i_opcode,
    input  logic                   i_out_ready,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    output gau_pkg::t_dp_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DONE
    } t_state;

    t_state                     r_state;
    logic [gau_pkg::CNT_W-1:0]  r_cnt;
    logic                       r_out_valid;
    logic                       w_accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.accept   = w_accept;
        o_cmd.step     = (r_state == S_MUL);
        o_cmd.last     = (r_state == S_MUL) && (r_cnt == gau_pkg::CNT_W'(gau_pkg::NSTEPS - 1));
        o_cmd.load_out = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= o_cmd.load_out || (r_out_valid && !i_out_ready);
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_cnt <= '0;
                        if (gau_pkg::t_opcode'(i_opcode) == gau_pkg::OP_ABSORB) begin
                            r_state <= S_MUL;
                        end else begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_MUL: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (o_cmd.last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (o_cmd.load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### src/gau_datapath.sv
// Key, accumulator, tag and digit-serial GF(2^128) multiplier datapath.
`timescale 1ns / 1ps

module gau_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gau_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [gau_pkg::HALF_W-1:0]        i_cfg_data,
    input  gau_pkg::t_dp_cmd                  i_cmd,
    input  logic [1:0]                        i_opcode,
    input  logic [gau_pkg::BLK_W-1:0]         i_block,
    input  logic [gau_pkg::VB_W-1:0]          i_valid_bytes,
    output logic [gau_pkg::BLK_W-1:0]         o_value,
    output logic                              o_tag_match
);

    logic [gau_pkg::HALF_W-1:0] r_key_h;
    logic [gau_pkg::HALF_W-1:0] r_key_l;
    logic [gau_pkg::BLK_W-1:0]  r_acc;
    logic [gau_pkg::BLK_W-1:0]  r_tag;
    logic [gau_pkg::BLK_W-1:0]  r_x;
    logic [gau_pkg::BLK_W-1:0]  r_v;
    logic [gau_pkg::BLK_W-1:0]  r_r;
    logic [gau_pkg::BLK_W-1:0]  r_res;
    logic                       r_res_match;
    logic [gau_pkg::BLK_W-1:0]  r_out;
    logic                       r_out_match;
    logic [gau_pkg::BLK_W-1:0]  n_v;
    logic [gau_pkg::BLK_W-1:0]  n_r;
    logic [gau_pkg::BLK_W-1:0]  w_masked;

    assign w_masked    = i_block & gau_pkg::byte_mask(i_valid_bytes);
    assign o_value     = r_out;
    assign o_tag_match = r_out_match;

    // eight bits of X per cycle, most significant first
    always_comb begin
        logic [gau_pkg::BLK_W-1:0] v;
        logic [gau_pkg::BLK_W-1:0] r;
        logic                      lsb;
        v = r_v;
        r = r_r;
        for (int j = 0; j < gau_pkg::DIGIT_W; j++) begin
            if (r_x[gau_pkg::BLK_W-1-j]) begin
                r = r ^ v;
            end
            lsb = v[0];
            v   = v >> 1;
            if (lsb) begin
                v = v ^ gau_pkg::GF_REDUCE;
            end
        end
        n_v = v;
        n_r = r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_h <= '0;
            r_key_l <= '0;
            r_acc   <= '0;
            r_tag   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (gau_pkg::t_cfg_idx'(i_cfg_index))
                    gau_pkg::CFG_KEY_HIGH: r_key_h <= i_cfg_data;
                    gau_pkg::CFG_KEY_LOW:  r_key_l <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.accept) begin
                unique case (gau_pkg::t_opcode'(i_opcode))
                    gau_pkg::OP_CLEAR:  r_acc <= '0;
                    gau_pkg::OP_FINISH: r_tag <= r_acc ^ i_block;
                    default: ;
                endcase
            end
            if (i_cmd.last) begin
                r_acc <= n_r;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            unique case (gau_pkg::t_opcode'(i_opcode))
                gau_pkg::OP_CLEAR: begin
                    r_res       <= '0;
                    r_res_match <= 1'b0;
                end
                gau_pkg::OP_ABSORB: begin
                    r_x         <= r_acc ^ w_masked;
                    r_v         <= {r_key_h, r_key_l};
                    r_r         <= '0;
                    r_res_match <= 1'b0;
                end
                gau_pkg::OP_FINISH: begin
                    r_res       <= r_acc ^ i_block;
                    r_res_match <= 1'b0;
                end
                gau_pkg::OP_CHECK: begin
                    r_res       <= r_tag;
                    r_res_match <= (i_block == r_tag);
                end
                default: ;
            endcase
        end
        if (i_cmd.step) begin
            r_x <= r_x << gau_pkg::DIGIT_W;
            r_v <= n_v;
            r_r <= n_r;
        end
        if (i_cmd.last) begin
            r_res <= n_r;
        end
        if (i_cmd.load_out) begin
            r_out       <= r_res;
            r_out_match <= r_res_match;
        end
    end

endmodule

### src/ghash_accumulator_unit.sv
// Top level of the GHASH accumulator unit.
`timescale 1ns / 1ps

// GCM GHASH accumulator. Write H through the config port (index 0 = bytes 0..7,
// index 1 = bytes 8..15) while idle. Each input transaction carries an opcode in
// tuser (clear, absorb, finish, check) and returns exactly one result. Absorb
// multiplies by H with a digit-serial GF(2^128) unit, eight bits per cycle, and
// then loads the product into the output register; the next transaction can be
// accepted once that load is done. Clear, finish and check skip the multiplier and
// load their result straight into the output register. One transaction is in
// flight at a time; the output register lets a new transaction be accepted while
// a result waits, and a stalled output holds the next finished result inside and
// blocks further input.

`include "ghash_accumulator_unit_assert.svh"

module ghash_accumulator_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [gau_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [gau_pkg::HALF_W-1:0]           i_cfg_data,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // tdata: block_high[63:0], block_low[127:64], valid_bytes[132:128], zero pad
    input  logic [gau_pkg::IN_DATA_W-1:0]        i_s_axis_tdata,
    // tuser: opcode[1:0]
    input  logic [1:0]                           i_s_axis_tuser,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // tdata: value_high[63:0], value_low[127:64], tag_match[128], zero pad
    output logic [gau_pkg::OUT_DATA_W-1:0]       o_m_axis_tdata
);

    gau_pkg::t_dp_cmd                 w_cmd;
    logic [gau_pkg::BLK_W-1:0]        w_block;
    logic [gau_pkg::BLK_W-1:0]        w_value;
    logic                             w_match;
    logic                             w_abs_go;
    logic                             w_out_free;

    assign w_block = {i_s_axis_tdata[63:0], i_s_axis_tdata[127:64]};
    assign o_m_axis_tdata = {7'd0, w_match, w_value[63:0], w_value[127:64]};
    assign w_abs_go   = w_cmd.accept && (i_s_axis_tuser == gau_pkg::OP_ABSORB);
    assign w_out_free = !o_m_axis_tvalid || i_m_axis_tready;

    gau_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_opcode    (i_s_axis_tuser),
        .i_out_ready (i_m_axis_tready),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    gau_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (w_cmd),
        .i_opcode      (i_s_axis_tuser),
        .i_block       (w_block),
        .i_valid_bytes (i_s_axis_tdata[132:128]),
        .o_value       (w_value),
        .o_tag_match   (w_match)
    );

    `GAU_ASSERT(a_step_busy, i_clk, i_rst_n, w_cmd.step |-> !o_s_axis_tready, "ready in multiply")
    `GAU_ASSERT(a_absorb_busy, i_clk, i_rst_n, w_abs_go |=> w_cmd.step, "absorb not started")
    `GAU_ASSERT(a_no_overwrite, i_clk, i_rst_n, w_cmd.load_out |-> w_out_free, "result lost")

endmodule
